[src/blf_pkg.sv]
`default_nettype none
package blf_pkg;

   // field and lane layout
   localparam int IN_W        = 16;
   localparam int OUT_W       = 16;
   localparam int LANES       = 4;
   localparam int LANE_ALPHA  = 0;
   localparam int LANE_BETA   = 1;
   localparam int LANE_THETA  = 2;
   localparam int LANE_PHI    = 3;
   localparam int AXES        = 3;
   localparam int AXIS_X      = 0;
   localparam int AXIS_Y      = 1;
   localparam int AXIS_Z      = 2;

   // rotator
   localparam int CORDIC_STEPS = 28;
   localparam int XY_W         = 33;
   localparam int Z_W          = 32;
   localparam int TRIG_W       = 18;
   localparam int TRIG_SHIFT   = 14;
   localparam logic signed [Z_W-1:0]  ANG_PI      = 32'sd843314857;
   localparam logic signed [Z_W-1:0]  ANG_HALF_PI = 32'sd421657428;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam int ATAN_ENTRIES = 10;
   localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
      32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287
   };

   // arithmetic widths
   localparam int PAIR_W = 2 * TRIG_W;
   localparam int VEL_W  = 35;
   localparam int DVT_W  = 34;
   localparam int TERM_W = 51;
   localparam int ACC_W  = 56;
   localparam int GRAV_W = 40;
   localparam int NUM_W  = 64;
   localparam int RATE_SHIFT = 10;
   localparam int GRAV_SHIFT = 16;

   // scaling to g and the division by 32174 * 2^21
   localparam longint GRAV_MILLI = 32174;
   localparam longint ACC_SCALE  = 1000;
   localparam int     QUO_SHIFT  = 21;
   localparam int     MQ_W       = NUM_W - QUO_SHIFT;
   localparam int     MLO_W      = 30;
   localparam int     RECIP_SHIFT = 45;
   localparam int     RECIP_W    = 31;
   localparam int     PROD_W     = MLO_W + RECIP_W;
   localparam int     QUO_W      = 16;
   localparam int     QD_W       = 31;
   localparam int     CMP_W      = 32;
   localparam logic [NUM_W-1:0]   HALF_DIV = NUM_W'(GRAV_MILLI) << (QUO_SHIFT - 1);
   localparam logic [MQ_W-1:0]    SAT_LIM  = MQ_W'(longint'(32768) * GRAV_MILLI);
   localparam logic [RECIP_W-1:0] RECIP    =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd32174);

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic        [IN_W-1:0] airspeed;
      logic signed [IN_W-1:0] roll_rate;
      logic signed [IN_W-1:0] pitch_rate;
      logic signed [IN_W-1:0] yaw_rate;
      logic signed [IN_W-1:0] airspeed_rate;
      logic signed [IN_W-1:0] attack_rate;
      logic signed [IN_W-1:0] sideslip_rate;
   } blf_pay_type;

   typedef struct packed {
      logic [LANES-1:0][Z_W-1:0] ang_z;
      logic [LANES-1:0]          ang_neg;
      blf_pay_type               pay;
   } blf_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } blf_fifo_stat_type;

   function automatic logic signed [Z_W-1:0] cordic_atan(input int unsigned step);
      logic signed [Z_W-1:0] a;
      if (step < ATAN_ENTRIES) begin
         a = ATAN_TAB[step[3:0]];
      end else begin
         a = Z_W'(32'sd1 <<< (28 - step));
      end
      return a;
   endfunction

   // product of two Q16 values, rounded back to Q16
   function automatic logic signed [TRIG_W-1:0] mul16(input logic signed [TRIG_W-1:0] a,
                                                       input logic signed [TRIG_W-1:0] b);
      logic signed [PAIR_W-1:0] p;
      logic signed [PAIR_W-1:0] r;
      p = PAIR_W'(a) * PAIR_W'(b);
      r = (p + PAIR_W'(32'sd32768)) >>> 16;
      return TRIG_W'(r);
   endfunction

endpackage
`default_nettype wire

[src/body_load_factor_core.sv]
`default_nettype none
// Body-axis load factors nx, ny, nz of one flight state per transaction.
// Request channel (req_): one transaction carries eleven 16-bit fields in
// req_tdata; the front folds the four angles into +-pi/2 and writes the
// transaction into a four-deep queue. The back pops it into a 39-stage pipe:
// 28 rotator steps for sin/cos of attack, sideslip, pitch and roll, then
// the trig pairs, velocity and rate products, the sums, the scaling to g and
// a reciprocal-multiply division by 32174 * 2^21 with saturation.
// Response channel (rsp_): rsp_tdata holds the three Q5.11 load factors.
// Throughput: one transaction per cycle while the response is not stalled,
// set by the pipelined rotator and multipliers (one per stage).
// Stall: while rsp_tvalid is high and rsp_tready low, the whole back pipe
// holds; the queue keeps taking requests until it fills, then req_tready drops.
// Reset: synchronous, active high; empties the queue and the pipe at once.
module body_load_factor_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // from bit 0 up: attack_angle, sideslip_angle, airspeed, pitch_attitude,
   // roll_attitude, roll_rate, pitch_rate, yaw_rate, airspeed_rate,
   // attack_rate, sideslip_rate (16 bits each)
   input  wire logic [175:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // from bit 0 up: nx_load, ny_load, nz_load (16 bits each)
   output logic [47:0]       rsp_tdata
);

   blf_pkg::blf_item_type      fr_item;
   blf_pkg::blf_item_type      q_head;
   blf_pkg::blf_fifo_stat_type q_stat;
   logic                       fr_push;
   logic                       bk_pop;

   // accept and fold angles
   blf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .stat       (q_stat),
      .push       (fr_push),
      .item       (fr_item)
   );

   // decouple front from back
   blf_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fr_push),
      .wr_item (fr_item),
      .pop     (bk_pop),
      .head    (q_head),
      .stat    (q_stat)
   );

   // compute and hold the result register
   blf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .stat       (q_stat),
      .pop        (bk_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

[src/blf_front.sv]
`default_nettype none
module blf_front (
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [175:0]              req_tdata,
   input  wire blf_pkg::blf_fifo_stat_type stat,
   output logic                           push,
   output blf_pkg::blf_item_type          item
);

   logic [blf_pkg::LANES-1:0][blf_pkg::IN_W-1:0] ang;
   logic signed [blf_pkg::Z_W-1:0] z_raw [blf_pkg::LANES];

   assign req_tready = !stat.full;
   assign push       = req_tvalid && req_tready;

   assign ang[blf_pkg::LANE_ALPHA] = req_tdata[15:0];
   assign ang[blf_pkg::LANE_BETA]  = req_tdata[31:16];
   assign ang[blf_pkg::LANE_THETA] = req_tdata[63:48];
   assign ang[blf_pkg::LANE_PHI]   = req_tdata[79:64];

   // widen to Q4.28 and fold into +-pi/2
   always_comb begin
      for (int l = 0; l < blf_pkg::LANES; l++) begin
         z_raw[l] = {ang[l][blf_pkg::IN_W-1], ang[l], 15'b0};
         priority if (z_raw[l] > blf_pkg::ANG_HALF_PI) begin
            item.ang_z[l]   = z_raw[l] - blf_pkg::ANG_PI;
            item.ang_neg[l] = 1'b1;
         end else if (z_raw[l] < -blf_pkg::ANG_HALF_PI) begin
            item.ang_z[l]   = z_raw[l] + blf_pkg::ANG_PI;
            item.ang_neg[l] = 1'b1;
         end else begin
            item.ang_z[l]   = z_raw[l];
            item.ang_neg[l] = 1'b0;
         end
      end
      item.pay.airspeed      = req_tdata[47:32];
      item.pay.roll_rate     = req_tdata[95:80];
      item.pay.pitch_rate    = req_tdata[111:96];
      item.pay.yaw_rate      = req_tdata[127:112];
      item.pay.airspeed_rate = req_tdata[143:128];
      item.pay.attack_rate   = req_tdata[159:144];
      item.pay.sideslip_rate = req_tdata[175:160];
   end

endmodule
`default_nettype wire

[src/blf_fifo.sv]
`default_nettype none
module blf_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire blf_pkg::blf_item_type  wr_item,
   input  wire logic                   pop,
   output blf_pkg::blf_item_type       head,
   output blf_pkg::blf_fifo_stat_type  stat
);

   blf_pkg::blf_item_type entry_ff [blf_pkg::FIFO_DEPTH];
   logic [blf_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [blf_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [blf_pkg::FIFO_PTR_W:0]   cnt_ff, cnt_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (blf_pkg::FIFO_PTR_W+1)'(blf_pkg::FIFO_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (blf_pkg::FIFO_PTR_W+1)'(blf_pkg::FIFO_DEPTH))
      else $error("queue count beyond depth");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!stat.full || pop))
      else $error("write into a full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("read from an empty queue");

endmodule
`default_nettype wire

[src/blf_back.sv]
`default_nettype none
module blf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire blf_pkg::blf_item_type  head,
   input  wire blf_pkg::blf_fifo_stat_type stat,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [47:0]                 rsp_tdata
);

   localparam int ST_TRIG = blf_pkg::CORDIC_STEPS + 1;
   localparam int ST_P1   = ST_TRIG + 1;
   localparam int ST_P2   = ST_P1 + 1;
   localparam int ST_P3   = ST_P2 + 1;
   localparam int ST_P4   = ST_P3 + 1;
   localparam int ST_F1   = ST_P4 + 1;
   localparam int ST_F2   = ST_F1 + 1;
   localparam int ST_F3   = ST_F2 + 1;
   localparam int ST_F4   = ST_F3 + 1;
   localparam int ST_OUT  = ST_F4 + 1;
   localparam int NSTG    = ST_OUT + 1;
   localparam int CS      = blf_pkg::CORDIC_STEPS;
   localparam int LN      = blf_pkg::LANES;
   localparam int AX      = blf_pkg::AXES;

   logic adv;
   logic [NSTG-1:0] vld_ff, vld_in;

   // rotator pipe
   logic signed [blf_pkg::XY_W-1:0] cx_ff [LN][CS+1];
   logic signed [blf_pkg::XY_W-1:0] cx_in [LN][CS+1];
   logic signed [blf_pkg::XY_W-1:0] cy_ff [LN][CS+1];
   logic signed [blf_pkg::XY_W-1:0] cy_in [LN][CS+1];
   logic signed [blf_pkg::Z_W-1:0]  cz_ff [LN][CS+1];
   logic signed [blf_pkg::Z_W-1:0]  cz_in [LN][CS+1];
   logic        cneg_ff [LN][CS+1];
   blf_pkg::blf_pay_type pay_ff [ST_P2+1];

   // trig results
   logic signed [blf_pkg::XY_W-1:0]   xr [LN];
   logic signed [blf_pkg::XY_W-1:0]   yr [LN];
   logic signed [blf_pkg::TRIG_W-1:0] sin_ff [LN], sin_in [LN];
   logic signed [blf_pkg::TRIG_W-1:0] cos_ff [LN], cos_in [LN];

   // P1
   logic signed [blf_pkg::TRIG_W-1:0] cbca_ff, cbsa_ff, sbca_ff, sbsa_ff, sb1_ff, cb1_ff, st1_ff;
   logic signed [blf_pkg::PAIR_W-1:0] ctsp1_ff, ctcp1_ff;
   // P2
   logic signed [blf_pkg::VEL_W-1:0]  vu_ff, vv_ff, vw_ff, vsbca_ff, vcb_ff, vsbsa_ff;
   logic signed [blf_pkg::VEL_W-1:0]  v17;
   logic signed [blf_pkg::DVT_W-1:0]  cbcavd2_ff, sbvd2_ff, cbsavd2_ff;
   logic signed [blf_pkg::TRIG_W-1:0] st2_ff;
   logic signed [blf_pkg::PAIR_W-1:0] ctsp2_ff, ctcp2_ff;
   // P3
   logic signed [blf_pkg::TERM_W-1:0] vsbca_bd_ff, vw_ad_ff, vcb_bd_ff, vsbsa_bd_ff, vu_ad_ff;
   logic signed [blf_pkg::TERM_W-1:0] q_vw_ff, r_vv_ff, r_vu_ff, p_vw_ff, p_vv_ff, q_vu_ff;
   logic signed [blf_pkg::DVT_W-1:0]  cbcavd3_ff, sbvd3_ff, cbsavd3_ff;
   logic signed [blf_pkg::TRIG_W-1:0] st3_ff;
   logic signed [blf_pkg::PAIR_W-1:0] ctsp3_ff, ctcp3_ff;
   // P4 .. output
   logic signed [blf_pkg::ACC_W-1:0]  acc_ff [AX], acc_in [AX];
   logic signed [blf_pkg::GRAV_W-1:0] grav_ff [AX], grav_in [AX];
   logic signed [blf_pkg::NUM_W-1:0]  num_ff [AX], num_in [AX];
   logic [blf_pkg::NUM_W-1:0]  mag [AX];
   logic [blf_pkg::MQ_W-1:0]   mq_ff [AX], mq_in [AX];
   logic                       neg2_ff [AX], neg3_ff [AX], neg4_ff [AX];
   logic                       sat3_ff [AX], sat3_in [AX], sat4_ff [AX];
   logic [blf_pkg::MLO_W-1:0]  mlo3_ff [AX], mlo4_ff [AX];
   logic [blf_pkg::PROD_W-1:0] prod_ff [AX], prod_in [AX];
   logic [blf_pkg::QUO_W-1:0]  q0_ff [AX], q0_in [AX];
   logic [blf_pkg::QD_W-1:0]   qd [AX];
   logic [blf_pkg::QUO_W-1:0]  qf [AX];
   logic [blf_pkg::QUO_W:0]    qm [AX];
   logic [blf_pkg::OUT_W-1:0]  out_ff [AX], out_in [AX];

   // hold the whole pipe only while a finished result waits
   assign adv        = !vld_ff[ST_OUT] || rsp_tready;
   assign pop        = !stat.empty && adv;
   assign vld_in     = {vld_ff[NSTG-2:0], pop};
   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = {out_ff[blf_pkg::AXIS_Z], out_ff[blf_pkg::AXIS_Y],
                        out_ff[blf_pkg::AXIS_X]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // rotator: one step per stage, four lanes side by side
   always_comb begin
      for (int l = 0; l < LN; l++) begin
         cx_in[l][0] = blf_pkg::CORDIC_GAIN;
         cy_in[l][0] = '0;
         cz_in[l][0] = head.ang_z[l];
         for (int s = 1; s <= CS; s++) begin
            if (cz_ff[l][s-1] >= 0) begin
               cx_in[l][s] = cx_ff[l][s-1] - (cy_ff[l][s-1] >>> (s - 1));
               cy_in[l][s] = cy_ff[l][s-1] + (cx_ff[l][s-1] >>> (s - 1));
               cz_in[l][s] = cz_ff[l][s-1] - blf_pkg::cordic_atan(s - 1);
            end else begin
               cx_in[l][s] = cx_ff[l][s-1] + (cy_ff[l][s-1] >>> (s - 1));
               cy_in[l][s] = cy_ff[l][s-1] - (cx_ff[l][s-1] >>> (s - 1));
               cz_in[l][s] = cz_ff[l][s-1] + blf_pkg::cordic_atan(s - 1);
            end
         end
         xr[l] = (cx_ff[l][CS] + blf_pkg::XY_W'(8192)) >>> blf_pkg::TRIG_SHIFT;
         yr[l] = (cy_ff[l][CS] + blf_pkg::XY_W'(8192)) >>> blf_pkg::TRIG_SHIFT;
         cos_in[l] = cneg_ff[l][CS] ? blf_pkg::TRIG_W'(-xr[l]) : blf_pkg::TRIG_W'(xr[l]);
         sin_in[l] = cneg_ff[l][CS] ? blf_pkg::TRIG_W'(-yr[l]) : blf_pkg::TRIG_W'(yr[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LN; l++) begin
            cneg_ff[l][0] <= head.ang_neg[l];
            for (int s = 0; s <= CS; s++) begin
               cx_ff[l][s] <= cx_in[l][s];
               cy_ff[l][s] <= cy_in[l][s];
               cz_ff[l][s] <= cz_in[l][s];
            end
            for (int s = 1; s <= CS; s++) begin
               cneg_ff[l][s] <= cneg_ff[l][s-1];
            end
            sin_ff[l] <= sin_in[l];
            cos_ff[l] <= cos_in[l];
         end
         pay_ff[0] <= head.pay;
         for (int s = 1; s <= ST_P2; s++) begin
            pay_ff[s] <= pay_ff[s-1];
         end
      end
   end

   // products and sums, one multiplier deep per stage
   assign v17 = blf_pkg::VEL_W'($signed({1'b0, pay_ff[ST_P1].airspeed}));

   always_ff @(posedge clock) begin
      if (adv) begin
         // P1: paired trig
         cbca_ff  <= blf_pkg::mul16(cos_ff[blf_pkg::LANE_BETA], cos_ff[blf_pkg::LANE_ALPHA]);
         cbsa_ff  <= blf_pkg::mul16(cos_ff[blf_pkg::LANE_BETA], sin_ff[blf_pkg::LANE_ALPHA]);
         sbca_ff  <= blf_pkg::mul16(sin_ff[blf_pkg::LANE_BETA], cos_ff[blf_pkg::LANE_ALPHA]);
         sbsa_ff  <= blf_pkg::mul16(sin_ff[blf_pkg::LANE_BETA], sin_ff[blf_pkg::LANE_ALPHA]);
         sb1_ff   <= sin_ff[blf_pkg::LANE_BETA];
         cb1_ff   <= cos_ff[blf_pkg::LANE_BETA];
         st1_ff   <= sin_ff[blf_pkg::LANE_THETA];
         ctsp1_ff <= blf_pkg::PAIR_W'(cos_ff[blf_pkg::LANE_THETA])
                     * blf_pkg::PAIR_W'(sin_ff[blf_pkg::LANE_PHI]);
         ctcp1_ff <= blf_pkg::PAIR_W'(cos_ff[blf_pkg::LANE_THETA])
                     * blf_pkg::PAIR_W'(cos_ff[blf_pkg::LANE_PHI]);
         // P2: velocity components and rate terms
         vu_ff    <= v17 * blf_pkg::VEL_W'(cbca_ff);
         vv_ff    <= v17 * blf_pkg::VEL_W'(sb1_ff);
         vw_ff    <= v17 * blf_pkg::VEL_W'(cbsa_ff);
         vsbca_ff <= v17 * blf_pkg::VEL_W'(sbca_ff);
         vcb_ff   <= v17 * blf_pkg::VEL_W'(cb1_ff);
         vsbsa_ff <= v17 * blf_pkg::VEL_W'(sbsa_ff);
         cbcavd2_ff <= blf_pkg::DVT_W'(cbca_ff)
                       * blf_pkg::DVT_W'($signed(pay_ff[ST_P1].airspeed_rate));
         sbvd2_ff   <= blf_pkg::DVT_W'(sb1_ff)
                       * blf_pkg::DVT_W'($signed(pay_ff[ST_P1].airspeed_rate));
         cbsavd2_ff <= blf_pkg::DVT_W'(cbsa_ff)
                       * blf_pkg::DVT_W'($signed(pay_ff[ST_P1].airspeed_rate));
         st2_ff   <= st1_ff;
         ctsp2_ff <= ctsp1_ff;
         ctcp2_ff <= ctcp1_ff;
         // P3: products with body and aerodynamic rates
         vsbca_bd_ff <= blf_pkg::TERM_W'(vsbca_ff)
                        * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].sideslip_rate));
         vw_ad_ff    <= blf_pkg::TERM_W'(vw_ff)
                        * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].attack_rate));
         vcb_bd_ff   <= blf_pkg::TERM_W'(vcb_ff)
                        * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].sideslip_rate));
         vsbsa_bd_ff <= blf_pkg::TERM_W'(vsbsa_ff)
                        * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].sideslip_rate));
         vu_ad_ff    <= blf_pkg::TERM_W'(vu_ff)
                        * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].attack_rate));
         q_vw_ff <= blf_pkg::TERM_W'(vw_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].pitch_rate));
         r_vv_ff <= blf_pkg::TERM_W'(vv_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].yaw_rate));
         r_vu_ff <= blf_pkg::TERM_W'(vu_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].yaw_rate));
         p_vw_ff <= blf_pkg::TERM_W'(vw_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].roll_rate));
         p_vv_ff <= blf_pkg::TERM_W'(vv_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].roll_rate));
         q_vu_ff <= blf_pkg::TERM_W'(vu_ff) * blf_pkg::TERM_W'($signed(pay_ff[ST_P2].pitch_rate));
         cbcavd3_ff <= cbcavd2_ff;
         sbvd3_ff   <= sbvd2_ff;
         cbsavd3_ff <= cbsavd2_ff;
         st3_ff     <= st2_ff;
         ctsp3_ff   <= ctsp2_ff;
         ctcp3_ff   <= ctcp2_ff;
         for (int a = 0; a < AX; a++) begin
            acc_ff[a]  <= acc_in[a];
            grav_ff[a] <= grav_in[a];
            num_ff[a]  <= num_in[a];
            mq_ff[a]   <= mq_in[a];
            neg2_ff[a] <= num_ff[a][blf_pkg::NUM_W-1];
            sat3_ff[a] <= sat3_in[a];
            neg3_ff[a] <= neg2_ff[a];
            mlo3_ff[a] <= mq_ff[a][blf_pkg::MLO_W-1:0];
            prod_ff[a] <= prod_in[a];
            q0_ff[a]   <= q0_in[a];
            mlo4_ff[a] <= mlo3_ff[a];
            sat4_ff[a] <= sat3_ff[a];
            neg4_ff[a] <= neg3_ff[a];
            out_ff[a]  <= out_in[a];
         end
      end
   end

   // P4: acceleration sums in Q32 ft/s^2, gravity in Q32 g
   always_comb begin
      acc_in[blf_pkg::AXIS_X] = (blf_pkg::ACC_W'(cbcavd3_ff) <<< blf_pkg::RATE_SHIFT)
         - blf_pkg::ACC_W'(vsbca_bd_ff) - blf_pkg::ACC_W'(vw_ad_ff)
         + blf_pkg::ACC_W'(q_vw_ff) - blf_pkg::ACC_W'(r_vv_ff);
      acc_in[blf_pkg::AXIS_Y] = (blf_pkg::ACC_W'(sbvd3_ff) <<< blf_pkg::RATE_SHIFT)
         + blf_pkg::ACC_W'(vcb_bd_ff) + blf_pkg::ACC_W'(r_vu_ff) - blf_pkg::ACC_W'(p_vw_ff);
      acc_in[blf_pkg::AXIS_Z] = blf_pkg::ACC_W'(vsbsa_bd_ff) - blf_pkg::ACC_W'(vu_ad_ff)
         - (blf_pkg::ACC_W'(cbsavd3_ff) <<< blf_pkg::RATE_SHIFT)
         - blf_pkg::ACC_W'(p_vv_ff) + blf_pkg::ACC_W'(q_vu_ff);
      grav_in[blf_pkg::AXIS_X] = blf_pkg::GRAV_W'(st3_ff) <<< blf_pkg::GRAV_SHIFT;
      grav_in[blf_pkg::AXIS_Y] = -blf_pkg::GRAV_W'(ctsp3_ff);
      grav_in[blf_pkg::AXIS_Z] = blf_pkg::GRAV_W'(ctcp3_ff);
   end

   // scale to g, then divide by 32174 * 2^21 with rounding half away from zero and saturation
   always_comb begin
      for (int a = 0; a < AX; a++) begin
         num_in[a] = blf_pkg::NUM_W'(acc_ff[a]) * blf_pkg::NUM_W'(blf_pkg::ACC_SCALE)
                   + blf_pkg::NUM_W'(grav_ff[a]) * blf_pkg::NUM_W'(blf_pkg::GRAV_MILLI);
         mag[a]    = (num_ff[a][blf_pkg::NUM_W-1] ? -num_ff[a] : num_ff[a]) + blf_pkg::HALF_DIV;
         mq_in[a]  = blf_pkg::MQ_W'(mag[a] >> blf_pkg::QUO_SHIFT);
         sat3_in[a] = (mq_ff[a] >= blf_pkg::SAT_LIM);
         prod_in[a] = blf_pkg::PROD_W'(mq_ff[a][blf_pkg::MLO_W-1:0])
                    * blf_pkg::PROD_W'(blf_pkg::RECIP);
         q0_in[a]  = blf_pkg::QUO_W'(prod_ff[a] >> blf_pkg::RECIP_SHIFT);
         qd[a]     = blf_pkg::QD_W'(q0_ff[a]) * blf_pkg::QD_W'(blf_pkg::GRAV_MILLI);
         // estimate is at most one short
         qf[a] = (blf_pkg::CMP_W'(mlo4_ff[a]) >=
                  blf_pkg::CMP_W'(qd[a]) + blf_pkg::CMP_W'(blf_pkg::GRAV_MILLI))
                 ? q0_ff[a] + 1'b1 : q0_ff[a];
         qm[a] = sat4_ff[a] ? (blf_pkg::QUO_W+1)'(32768) : {1'b0, qf[a]};
         priority if (neg4_ff[a]) begin
            out_in[a] = blf_pkg::OUT_W'(-qm[a]);
         end else if (sat4_ff[a]) begin
            out_in[a] = blf_pkg::OUT_W'(16'h7fff);
         end else begin
            out_in[a] = blf_pkg::OUT_W'(qm[a]);
         end
      end
   end

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipe moved while the result was stalled");
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_F4] && adv && sat4_ff[blf_pkg::AXIS_X] && !neg4_ff[blf_pkg::AXIS_X])
      |=> out_ff[blf_pkg::AXIS_X] == 16'h7fff)
      else $error("positive overflow not clamped");
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_F4] && !sat4_ff[blf_pkg::AXIS_Y]) |-> !q0_ff[blf_pkg::AXIS_Y][blf_pkg::QUO_W-1])
      else $error("quotient estimate out of range");

endmodule
`default_nettype wire

[tb/sv/tb_body_load_factor_core.sv]
`default_nettype none
// Load-factor core bench: a queue-fed driver offers flight states, a clocked
// monitor compares every response against a bit-exact software prediction.
module tb_body_load_factor_core;

   localparam int N_RANDOM   = 1800;
   localparam int DRAIN_WAIT = 120;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;

   body_load_factor_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   logic [175:0] state_queue [$];
   logic [47:0]  load_queue [$];
   int           error_count = 0;
   int           states_sent = 0;
   int           loads_seen = 0;
   bit           stimulus_done = 1'b0;
   bit           quiet_phase = 1'b0;
   int           hold_off = 0;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------
   function automatic void sin_cos(input logic signed [15:0] ang,
                                   output longint s16, output longint c16);
      longint z, x, y, nx, a;
      bit     neg;
      z   = longint'(ang) * 32768;
      x   = 652032874;
      y   = 0;
      neg = 1'b0;
      // fold beyond +-pi/2 back by pi and flip sign afterwards
      if (z > 421657428) begin
         z = z - 843314857; neg = 1'b1;
      end else if (z < -421657428) begin
         z = z + 843314857; neg = 1'b1;
      end
      for (int i = 0; i < 28; i++) begin
         case (i)
            0: a = 210828714;
            1: a = 124459457;
            2: a = 65760959;
            3: a = 33381290;
            4: a = 16755422;
            5: a = 8385879;
            6: a = 4193963;
            7: a = 2097109;
            8: a = 1048571;
            9: a = 524287;
            default: a = longint'(1) <<< (28 - i);
         endcase
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z = z - a;
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z = z + a;
         end
         x = nx;
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      c16 = neg ? -x : x;
      s16 = neg ? -y : y;
   endfunction

   function automatic longint trig_product(input longint a, input longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   // scale to g, round half away from zero, saturate
   function automatic logic [15:0] to_g(input longint accel, input longint grav);
      longint n, mag, qm;
      n   = accel * 1000 + grav * 32174;
      mag = (n < 0) ? -n : n;
      qm  = (mag + (longint'(32174) << 20)) / (longint'(32174) << 21);
      if (qm > 32768) qm = 32768;
      if (n < 0) qm = -qm;
      if (qm > 32767) qm = 32767;
      return qm[15:0];
   endfunction

   function automatic logic [47:0] predict_loads(input logic [175:0] st);
      longint sa, ca, sb, cb, sth, cth, sph, cph;
      longint cbca, cbsa, sbca, sbsa, vu, vv, vw, du, dv, dw;
      longint v, p, q, r, vd, ad, bd;
      v  = longint'(st[47:32]);
      p  = longint'($signed(st[95:80]));
      q  = longint'($signed(st[111:96]));
      r  = longint'($signed(st[127:112]));
      vd = longint'($signed(st[143:128]));
      ad = longint'($signed(st[159:144]));
      bd = longint'($signed(st[175:160]));
      sin_cos(st[15:0], sa, ca);
      sin_cos(st[31:16], sb, cb);
      sin_cos(st[63:48], sth, cth);
      sin_cos(st[79:64], sph, cph);
      cbca = trig_product(cb, ca);
      cbsa = trig_product(cb, sa);
      sbca = trig_product(sb, ca);
      sbsa = trig_product(sb, sa);
      vu = v * cbca;
      vv = v * sb;
      vw = v * cbsa;
      du = cbca * vd * 1024 - (v * sbca) * bd - vw * ad;
      dv = sb * vd * 1024 + (v * cb) * bd;
      dw = cbsa * vd * 1024 - (v * sbsa) * bd + vu * ad;
      return {to_g(-(dw + p * vv - q * vu), cth * cph),
              to_g(dv + r * vu - p * vw, -(cth * sph)),
              to_g(du + q * vw - r * vv, sth * 65536)};
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [175:0] st;
      // all zero, all max, all min, all ones
      state_queue.push_back('0);
      state_queue.push_back({11{16'h7FFF}});
      state_queue.push_back({11{16'h8000}});
      state_queue.push_back({11{16'hFFFF}});
      // angles at and around +-pi/2 (12868 ~ pi/2 in Q3.13), at +-pi and full scale
      foreach (st[i]) st[i] = 1'b0;
      for (int k = 0; k < 8; k++) begin
         logic [15:0] ang;
         case (k)
            0: ang = 16'sd12868;
            1: ang = 16'sd12869;
            2: ang = -16'sd12868;
            3: ang = -16'sd12869;
            4: ang = 16'sd25736;
            5: ang = -16'sd25736;
            6: ang = 16'h7FFF;
            default: ang = 16'h8000;
         endcase
         st = {{6{16'sd4096}}, ang, ang, 16'd16000, ang, ang};
         state_queue.push_back(st);
      end
      // saturation: top airspeed, full rates
      state_queue.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h0, 16'h0, 16'hFFFF, 16'h1000, 16'h1000});
      state_queue.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                             16'h8000, 16'h0, 16'h0, 16'hFFFF, 16'hF000, 16'h0});
      for (int n = 0; n < N_RANDOM; n++) begin
         for (int f = 0; f < 11; f++) st[f*16 +: 16] = rand_field();
         state_queue.push_back(st);
      end
   end

   // ---------------------------------------------------------------
   // driver: idles about a third of the time, never between items 200..600
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) states_sent <= states_sent + 1;
         if (!req_tvalid || req_tready) begin
            quiet_phase = (states_sent >= 200 && states_sent < 600);
            if (state_queue.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 34)) begin
               req_tdata  <= state_queue[0];
               load_queue.push_back(predict_loads(state_queue[0]));
               void'(state_queue.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
               if (state_queue.size() == 0) stimulus_done = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor and receiver; one long hold-off fills the queue and stalls input
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            loads_seen <= loads_seen + 1;
            if (load_queue.size() == 0) begin
               $error("response with no state outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = load_queue.pop_front();
               if (rsp_tdata[15:0] !== want[15:0]) begin
                  $error("nx_load expected %h got %h", want[15:0], rsp_tdata[15:0]);
                  error_count++;
               end
               if (rsp_tdata[31:16] !== want[31:16]) begin
                  $error("ny_load expected %h got %h", want[31:16], rsp_tdata[31:16]);
                  error_count++;
               end
               if (rsp_tdata[47:32] !== want[47:32]) begin
                  $error("nz_load expected %h got %h", want[47:32], rsp_tdata[47:32]);
                  error_count++;
               end
            end
         end
         if (loads_seen == 100 && hold_off == 0) hold_off = 300;
         if (hold_off > 1) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            if (hold_off == 1) hold_off = -1;
            rsp_tready <= (loads_seen >= 200 && loads_seen < 600) ||
                          ($urandom_range(0, 99) >= 34);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !req_tvalid && load_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d flight states incl. extremes, angle folds and saturation",
               states_sent);
      $display("with random stalls on both channels and one long response hold-off");
      if (error_count == 0 && !rsp_tvalid) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
